// File: rtl/voice_slot_allocator_macros.svh
// Assertion macros shared by the voice slot allocator modules
`ifndef VOICE_SLOT_ALLOCATOR_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define VSA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define VSA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vsa_pkg.sv
// Shared constants, opcodes and control structs for the voice slot allocator
package vsa_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int TAG_W  = 16;
  localparam int SND_W  = 10;
  localparam int PRIO_W = 16;
  localparam int SIDX_W = 4;
  localparam int SLOT_W = 4;
  localparam int ACT_W  = 5;

  // Defaults
  localparam int               NUM_SLOTS_DEF = 16;
  localparam logic [ACT_W-1:0] ACTIVE_RESET  = 5'd16;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP_ORG = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP_ALL = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, clear scan trackers
    logic step;    // issue next slot read
    logic commit;  // update table, load result register
  } vsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_op;    // captured opcode needs a table scan
    logic live_zero;  // no live slots (active count is zero)
    logic last;       // read address is the last live slot
    logic out_stall;  // result register full and not being taken
  } vsa_sts_t;

endpackage

// File: rtl/vsa_req_if.sv
// Request channel: one table operation per transaction
interface vsa_req_if import vsa_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [TAG_W-1:0]         origin_tag;
  logic                     origin_valid;
  logic [SND_W-1:0]         sound_id;
  logic                     id_valid;
  logic signed [PRIO_W-1:0] priority_req;
  logic [SIDX_W-1:0]        slot_index;

  modport source (
    output valid, opcode, origin_tag, origin_valid, sound_id, id_valid,
           priority_req, slot_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, origin_tag, origin_valid, sound_id, id_valid,
           priority_req, slot_index,
    output ready
  );
endinterface

// File: rtl/vsa_rsp_if.sv
// Response channel: one result per request transaction
interface vsa_rsp_if import vsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [SLOT_W-1:0] slot;
  logic              evicted;
  logic              playing;

  modport source (output valid, granted, slot, evicted, playing, input ready);
  modport sink   (input valid, granted, slot, evicted, playing, output ready);
endinterface

// File: rtl/vsa_cfg_if.sv
// Configuration channel: writes the active slot count
interface vsa_cfg_if import vsa_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] active_slots;

  modport source (output valid, active_slots, input ready);
  modport sink   (input valid, active_slots, output ready);
endinterface

// File: rtl/vsa_ctrl.sv
// Sequencer for request capture, slot scan, table update and result hand-off
`include "voice_slot_allocator_macros.svh"

module vsa_ctrl import vsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output vsa_cmd_t cmd,
  input  vsa_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.scan_op && !sts.live_zero) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      // last read word is compared here
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_stall) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `VSA_ASSERT_NXT(a_load_to_start, clk, rst, cmd.load, state == S_START, "load did not start")
  `VSA_ASSERT_IMP(a_drain_after_scan, clk, rst, state == S_DRAIN, $past(state) == S_SCAN, "drain without scan")
  `VSA_ASSERT_IMP(a_scan_needed, clk, rst, state == S_SCAN, sts.scan_op && !sts.live_zero, "scan not needed")
  `VSA_ASSERT_NXT(a_commit_to_idle, clk, rst, cmd.commit, state == S_IDLE, "commit did not return to idle")

endmodule

// File: rtl/vsa_datapath.sv
// Slot table, scan compare trackers, table update and result register
`include "voice_slot_allocator_macros.svh"

module vsa_datapath import vsa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  vsa_cmd_t                 cmd,
  output vsa_sts_t                 sts,
  // configuration
  input  logic                     cfg_valid,
  input  logic [ACT_W-1:0]         cfg_active,
  // request payload
  input  logic [OP_W-1:0]          in_opcode,
  input  logic [TAG_W-1:0]         in_origin_tag,
  input  logic                     in_origin_valid,
  input  logic [SND_W-1:0]         in_sound_id,
  input  logic                     in_id_valid,
  input  logic signed [PRIO_W-1:0] in_priority_req,
  input  logic [SIDX_W-1:0]        in_slot_index,
  // result
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_granted,
  output logic [SLOT_W-1:0]        out_slot,
  output logic                     out_evicted,
  output logic                     out_playing
);

  localparam int IW   = $clog2(NUM_SLOTS);
  localparam int CW   = $clog2(NUM_SLOTS + 1);
  localparam int CMPW = (CW > ACT_W) ? CW : ACT_W;

  // Configuration and captured request
  logic [ACT_W-1:0]         active_slots;
  logic [OP_W-1:0]          op;
  logic [TAG_W-1:0]         tag;
  logic                     ovalid;
  logic [SND_W-1:0]         sound;
  logic                     ivalid;
  logic signed [PRIO_W-1:0] prio;
  logic [SIDX_W-1:0]        sidx;

  // Slot flags and payload memories
  logic [NUM_SLOTS-1:0]     busy;
  logic [NUM_SLOTS-1:0]     has_org;
  logic [NUM_SLOTS-1:0]     busy_next;
  logic [NUM_SLOTS-1:0]     has_org_next;
  logic [TAG_W-1:0]         mem_origin [NUM_SLOTS];
  logic [SND_W-1:0]         mem_sound  [NUM_SLOTS];
  logic signed [PRIO_W-1:0] mem_prio   [NUM_SLOTS];
  logic [TAG_W-1:0]         rd_origin;
  logic [SND_W-1:0]         rd_sound;
  logic signed [PRIO_W-1:0] rd_prio;

  // Scan state
  logic [IW-1:0]            rd_idx;
  logic                     cmp_valid;
  logic [IW-1:0]            cmp_idx;
  logic                     hit_found;
  logic [IW-1:0]            hit_idx;
  logic                     hit_evict;
  logic                     min_found;
  logic [IW-1:0]            min_idx;
  logic signed [PRIO_W-1:0] min_val;
  logic                     play;

  // Derived
  logic [CMPW-1:0]          act_ext;
  logic [CMPW-1:0]          live_ext;
  logic [NUM_SLOTS-1:0]     live_mask;
  logic                     c_busy;
  logic                     c_ho;
  logic                     org_eq;
  logic                     snd_eq;
  logic                     prio_lt;
  logic                     sidx_in;
  logic [IW-1:0]            sidx_i;
  logic [IW-1:0]            pick;
  logic                     set_en;
  logic [NUM_SLOTS-1:0]     clr_mask;
  logic                     res_granted;
  logic [SLOT_W-1:0]        res_slot;
  logic                     res_evicted;
  logic                     res_playing;

  // Active count register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      active_slots <= cfg_active;
    end
  end

  // Live count clamped to the table size, and its slot mask
  always_comb begin
    act_ext  = CMPW'(active_slots);
    live_ext = (act_ext > CMPW'(NUM_SLOTS)) ? CMPW'(NUM_SLOTS) : act_ext;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      live_mask[i] = CMPW'(i) < live_ext;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_opcode;
      tag    <= in_origin_tag;
      ovalid <= in_origin_valid;
      sound  <= in_sound_id;
      ivalid <= in_id_valid;
      prio   <= in_priority_req;
      sidx   <= in_slot_index;
    end
  end

  // Status to the controller
  always_comb begin
    sts.scan_op   = (op == OP_ALLOC) || (op == OP_STOP_ORG) || (op == OP_QUERY);
    sts.live_zero = (live_ext == '0);
    sts.last      = (CMPW'(rd_idx) + CMPW'(1)) == live_ext;
    sts.out_stall = out_valid && !out_ready;
  end

  // Memory read port, one slot a cycle
  always_ff @(posedge clk) begin
    rd_origin <= mem_origin[rd_idx];
    rd_sound  <= mem_sound[rd_idx];
    rd_prio   <= mem_prio[rd_idx];
  end

  // Memory write port, on an allocate that found a slot
  always_ff @(posedge clk) begin
    if (cmd.commit && set_en) begin
      mem_origin[pick] <= tag;
      mem_sound[pick]  <= sound;
      mem_prio[pick]   <= prio;
    end
  end

  // Compare terms for the slot whose data has just been read
  always_comb begin
    c_busy  = busy[cmp_idx];
    c_ho    = has_org[cmp_idx];
    org_eq  = (rd_origin == tag);
    snd_eq  = (rd_sound == sound);
    prio_lt = (rd_prio < min_val);
  end

  // Read address and compare stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.step) begin
      rd_idx <= rd_idx + 1'b1;
    end
    cmp_idx <= rd_idx;
  end

  // Scan trackers: first hit, lowest priority below the request, any match
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found <= 1'b0;
      min_found <= 1'b0;
      min_val   <= in_priority_req;
      play      <= 1'b0;
    end else if (cmp_valid) begin
      if (op == OP_ALLOC) begin
        if (!hit_found && !c_busy) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
          hit_evict <= 1'b0;
        end else if (!hit_found && ovalid && c_ho && org_eq) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
          hit_evict <= 1'b1;
        end
        if (c_busy && prio_lt) begin
          min_found <= 1'b1;
          min_idx   <= cmp_idx;
          min_val   <= rd_prio;
        end
      end
      if (op == OP_STOP_ORG && !hit_found && c_busy && (c_ho == ovalid) &&
          (!ovalid || org_eq)) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
      end
      if (op == OP_QUERY && ((ovalid && c_ho && org_eq) || (ivalid && c_busy && snd_eq))) begin
        play <= 1'b1;
      end
    end
  end

  // Table update and result per opcode
  always_comb begin
    sidx_in     = CMPW'(sidx) < live_ext;
    sidx_i      = IW'(sidx);
    pick        = hit_found ? hit_idx : min_idx;
    set_en      = 1'b0;
    clr_mask    = '0;
    res_granted = 1'b0;
    res_slot    = '0;
    res_evicted = 1'b0;
    res_playing = 1'b0;
    unique case (op)
      OP_ALLOC: begin
        if (hit_found || min_found) begin
          set_en      = 1'b1;
          res_granted = 1'b1;
          res_slot    = SLOT_W'(pick);
          res_evicted = hit_found ? hit_evict : 1'b1;
        end
      end
      OP_STOP_ORG: begin
        if (hit_found) begin
          clr_mask[hit_idx] = 1'b1;
          res_granted       = 1'b1;
          res_slot          = SLOT_W'(hit_idx);
        end
      end
      OP_STOP_ALL: begin
        clr_mask    = live_mask;
        res_granted = |(busy & live_mask);
      end
      OP_RELEASE: begin
        if (sidx_in) begin
          res_slot = sidx;
          if (busy[sidx_i]) begin
            clr_mask[sidx_i] = 1'b1;
            res_granted      = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        res_playing = play;
      end
      default: begin
        res_granted = 1'b0;
      end
    endcase
  end

  // Next slot flags: clear the freed slots, then mark an allocated one
  always_comb begin
    busy_next    = busy & ~clr_mask;
    has_org_next = has_org & ~clr_mask;
    if (set_en) begin
      busy_next[pick]    = 1'b1;
      has_org_next[pick] = ovalid;
    end
  end

  // Slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= '0;
      has_org <= '0;
    end else if (cmd.commit) begin
      busy    <= busy_next;
      has_org <= has_org_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted <= res_granted;
      out_slot    <= res_slot;
      out_evicted <= res_evicted;
      out_playing <= res_playing;
    end
  end

  `VSA_ASSERT_IMP(a_alloc_free_slot, clk, rst, cmd.commit && set_en && !res_evicted,
                  !busy[pick], "non-evicting allocate took a busy slot")
  `VSA_ASSERT_NXT(a_alloc_marks_busy, clk, rst, cmd.commit && set_en,
                  busy[$past(pick)], "allocated slot not busy")
  `VSA_ASSERT_IMP(a_commit_room, clk, rst, cmd.commit, !out_valid || out_ready,
                  "result overwritten")

endmodule

// File: rtl/voice_slot_allocator.sv
// Top level of the voice slot allocator: controller and datapath
//
//  channel | dir | transaction moves
//  --------+-----+------------------------------------------------------------
//  req     | in  | opcode, origin, sound id, priority, slot index
//  rsp     | out | granted, slot, evicted, playing
//  cfg     | in  | active_slots (always ready)
//
//  Scanning opcodes (allocate, stop by origin, query) read the live slots one
//  slot a cycle through the single read port, then compare the last one and
//  commit; other opcodes, and scans with no live slot, go straight to commit.
//  A new request is taken in the cycle after the commit, while the result may
//  still wait in its register; a stalled result holds the following commit.
//  Reset is synchronous and frees every slot at once.

module voice_slot_allocator import vsa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  vsa_req_if.sink  req,
  vsa_rsp_if.source rsp,
  vsa_cfg_if.sink  cfg
);

  vsa_cmd_t cmd;
  vsa_sts_t sts;

  // Configuration writes are taken in any cycle
  assign cfg.ready = 1'b1;

  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vsa_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg.valid),
    .cfg_active      (cfg.active_slots),
    .in_opcode       (req.opcode),
    .in_origin_tag   (req.origin_tag),
    .in_origin_valid (req.origin_valid),
    .in_sound_id     (req.sound_id),
    .in_id_valid     (req.id_valid),
    .in_priority_req (req.priority_req),
    .in_slot_index   (req.slot_index),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_granted     (rsp.granted),
    .out_slot        (rsp.slot),
    .out_evicted     (rsp.evicted),
    .out_playing     (rsp.playing)
  );

endmodule
